// ===== hw/rtl/hsvb_pkg.sv =====
// Shared constants and types for the Hadamard state vector butterfly core.
package hsvb_pkg;

    // Default sizing of the core
    localparam int DEF_MAX_QUBITS = 12;
    localparam int DEF_AMP_WIDTH  = 16;

    // Configuration register fields
    localparam int CFG_DATA_W = 4;
    // Effective qubit count and target width (covers qubit counts up to 31)
    localparam int QC_W = 5;

    // 1/sqrt(2) as 46341/65536, rounded to nearest with ties toward plus infinity
    localparam int                     SCALE_W     = 17;
    localparam logic signed [SCALE_W-1:0] SCALE_NUM = 17'sd46341;
    localparam int                     FRAC_SHIFT  = 16;
    localparam int                     ROUND_BIAS  = 32768;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TARGET_BIT  = 1'b0,
        CFG_QUBIT_COUNT = 1'b1
    } cfg_reg_t;

endpackage

// ===== hw/rtl/hsvb_ram.sv =====
// Generic single-port RAM with registered read data.
module hsvb_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, capture read data on re, hold it otherwise
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hadamard_state_vector_butterfly_core.sv =====
// Top level: streaming single-qubit Hadamard butterfly over a complex state vector.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------------
//  s_      | in        | s_valid / s_ready     | s_amp_re, s_amp_im
//  m_      | out       | m_valid / m_ready     | m_state_index, m_out_re, m_out_im,
//          |           |                       | m_run_last, m_vector_end
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
//  One item is accepted per cycle while the pipeline has room for it. An item with target bit 0
//  is written to the partner RAM and gives no result; its partner reads the RAM and gives two
//  results, one per cycle on the m_ channel while m_ready is high, lower result first, so a run
//  of upper items is taken no faster than their results leave on the m_ channel.
//  From accepting the upper item to its lower result showing, the item passes the RAM read
//  and input capture at the accepting edge, the sum/difference register and the
//  scale-and-saturate register.
//  Reset clears the position counter, the stage valid bits and sets target_bit 0 and
//  qubit_count 12; the partner RAM is not cleared. Stalls on m_ready back up through the
//  pipeline; an item with target bit 0 is still taken while the pipeline is full.
module hadamard_state_vector_butterfly_core
    import hsvb_pkg::*;
#(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    parameter int AMP_WIDTH  = DEF_AMP_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [AMP_WIDTH-1:0] s_amp_re,
    input  logic signed [AMP_WIDTH-1:0] s_amp_im,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [MAX_QUBITS-1:0]       m_state_index,
    output logic signed [AMP_WIDTH-1:0] m_out_re,
    output logic signed [AMP_WIDTH-1:0] m_out_im,
    output logic                        m_run_last,
    output logic                        m_vector_end,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [0:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW     = AMP_WIDTH;
    localparam int SW     = AW + 1;
    localparam int PW     = SW + SCALE_W;
    localparam int QW     = PW - FRAC_SHIFT;
    localparam int ADDR_W = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
    localparam int IW     = MAX_QUBITS;

    // Configuration registers
    logic [CFG_DATA_W-1:0] target_bit_reg;
    logic [CFG_DATA_W-1:0] qubit_count_reg;

    // Position counter
    logic [IW-1:0] position_count_reg;
    logic [IW-1:0] position_count_next;

    // Address generation
    logic [QC_W-1:0] qc_eff;
    logic [QC_W-1:0] tb_eff;
    logic [IW-1:0]   len_mask;
    logic [IW-1:0]   stride;
    logic [IW-1:0]   idx;
    logic [IW-1:0]   low_mask;
    logic [IW-1:0]   buf_addr;
    logic            is_upper;
    logic            in_accept;

    // Partner RAM
    logic              ram_we;
    logic              ram_re;
    logic [2*AW-1:0]   ram_rdata;
    logic signed [AW-1:0] a_re;
    logic signed [AW-1:0] a_im;

    // Stage 1: RAM read data and the upper amplitude
    logic                 s1_valid_reg;
    logic signed [AW-1:0] s1_re_reg;
    logic signed [AW-1:0] s1_im_reg;
    logic [IW-1:0]        s1_lo_idx_reg;
    logic [IW-1:0]        s1_hi_idx_reg;
    logic                 s1_last_reg;

    // Stage 2: sums and differences
    logic                 s2_valid_reg;
    logic signed [SW-1:0] s2_sum_reg [4];
    logic signed [SW-1:0] s2_sum_next [4];
    logic [IW-1:0]        s2_lo_idx_reg;
    logic [IW-1:0]        s2_hi_idx_reg;
    logic                 s2_last_reg;

    // Result pair register
    logic                 pair_valid_reg;
    logic                 pair_phase_reg;
    logic [AW-1:0]        pair_val_reg [4];
    logic [AW-1:0]        pair_val_next [4];
    logic [IW-1:0]        pair_lo_idx_reg;
    logic [IW-1:0]        pair_hi_idx_reg;
    logic                 pair_last_reg;

    // Scaling lanes
    logic signed [PW-1:0] prod [4];
    logic signed [PW-1:0] rnd [4];
    logic [QW-1:0]        qv [4];

    // Pipeline advance
    logic out_accept;
    logic pair_done;
    logic en_pair;
    logic en2;
    logic en1;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_bit_reg  <= '0;
            qubit_count_reg <= CFG_DATA_W'(DEF_MAX_QUBITS);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_TARGET_BIT:  target_bit_reg  <= cfg_data;
                CFG_QUBIT_COUNT: qubit_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the configuration and build the buffer address from the position
    always_comb begin
        if (qubit_count_reg == '0) begin
            qc_eff = QC_W'(1);
        end else if (QC_W'(qubit_count_reg) > QC_W'(MAX_QUBITS)) begin
            qc_eff = QC_W'(MAX_QUBITS);
        end else begin
            qc_eff = QC_W'(qubit_count_reg);
        end
        if (QC_W'(target_bit_reg) >= qc_eff) begin
            tb_eff = qc_eff - QC_W'(1);
        end else begin
            tb_eff = QC_W'(target_bit_reg);
        end
        len_mask = ~({IW{1'b1}} << qc_eff);
        stride   = IW'(1) << tb_eff;
        low_mask = stride - IW'(1);
        idx      = position_count_reg & len_mask;
        is_upper = |(idx & stride);
        // Drop the target bit from the index
        buf_addr = (idx & low_mask) | ((idx >> 1) & ~low_mask);
        position_count_next = (idx + IW'(1)) & len_mask;
    end

    // Advance each stage when the next one is free or draining
    assign out_accept = m_valid && m_ready;
    assign pair_done  = out_accept && pair_phase_reg;
    assign en_pair    = !pair_valid_reg || pair_done;
    assign en2        = !s2_valid_reg || en_pair;
    assign en1        = !s1_valid_reg || en2;
    assign s_ready    = !is_upper || en1;
    assign in_accept  = s_valid && s_ready;

    assign ram_we = in_accept && !is_upper;
    assign ram_re = in_accept && is_upper;

    hsvb_ram #(
        .WIDTH  (2 * AW),
        .ADDR_W (ADDR_W)
    ) u_partner_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (buf_addr[ADDR_W-1:0]),
        .wdata ({s_amp_re, s_amp_im}),
        .rdata (ram_rdata)
    );

    // Advance the position on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_count_reg <= '0;
        end else if (in_accept) begin
            position_count_reg <= position_count_next;
        end
    end

    // Stage 1: hold the upper amplitude while its partner is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= ram_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            s1_re_reg     <= s_amp_re;
            s1_im_reg     <= s_amp_im;
            s1_lo_idx_reg <= idx ^ stride;
            s1_hi_idx_reg <= idx;
            s1_last_reg   <= (idx == len_mask);
        end
    end

    // Form the exact sums and differences
    assign a_re = ram_rdata[2*AW-1:AW];
    assign a_im = ram_rdata[AW-1:0];

    always_comb begin
        s2_sum_next[0] = {a_re[AW-1], a_re} + {s1_re_reg[AW-1], s1_re_reg};
        s2_sum_next[1] = {a_im[AW-1], a_im} + {s1_im_reg[AW-1], s1_im_reg};
        s2_sum_next[2] = {a_re[AW-1], a_re} - {s1_re_reg[AW-1], s1_re_reg};
        s2_sum_next[3] = {a_im[AW-1], a_im} - {s1_im_reg[AW-1], s1_im_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && s1_valid_reg) begin
            s2_sum_reg    <= s2_sum_next;
            s2_lo_idx_reg <= s1_lo_idx_reg;
            s2_hi_idx_reg <= s1_hi_idx_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Scale by 1/sqrt(2), round to nearest and saturate, one lane per value
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod[i] = s2_sum_reg[i] * SCALE_NUM;
            rnd[i]  = prod[i] + $signed(PW'(ROUND_BIAS));
            qv[i]   = rnd[i][PW-1:FRAC_SHIFT];
            if ((&qv[i][QW-1:AW-1]) || !(|qv[i][QW-1:AW-1])) begin
                pair_val_next[i] = qv[i][AW-1:0];
            end else if (qv[i][QW-1]) begin
                pair_val_next[i] = {1'b1, {(AW-1){1'b0}}};
            end else begin
                pair_val_next[i] = {1'b0, {(AW-1){1'b1}}};
            end
        end
    end

    // Result pair: show the lower result, then the upper one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            pair_phase_reg <= 1'b0;
        end else if (en_pair) begin
            pair_valid_reg <= s2_valid_reg;
            pair_phase_reg <= 1'b0;
        end else if (out_accept) begin
            pair_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_pair && s2_valid_reg) begin
            pair_val_reg    <= pair_val_next;
            pair_lo_idx_reg <= s2_lo_idx_reg;
            pair_hi_idx_reg <= s2_hi_idx_reg;
            pair_last_reg   <= s2_last_reg;
        end
    end

    assign m_valid       = pair_valid_reg;
    assign m_state_index = pair_phase_reg ? pair_hi_idx_reg : pair_lo_idx_reg;
    assign m_out_re      = pair_phase_reg ? pair_val_reg[2] : pair_val_reg[0];
    assign m_out_im      = pair_phase_reg ? pair_val_reg[3] : pair_val_reg[1];
    assign m_run_last    = pair_phase_reg;
    assign m_vector_end  = pair_phase_reg && pair_last_reg;

    // A taken lower result is always followed by the upper result of its pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_accept && !m_run_last |=> m_valid && m_run_last)
        else $error("upper result missing after lower result");

    // An accepted upper item enters the read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && is_upper |=> s1_valid_reg)
        else $error("upper item lost at read stage");

    // Input stalls only for an item that needs the pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> is_upper && s1_valid_reg && s2_valid_reg && pair_valid_reg)
        else $error("input stalled with room in pipeline");

    // A stored item never produces a result stage entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !is_upper && en1 |=> !s1_valid_reg)
        else $error("stored item entered read stage");

endmodule
